### rtl/core/bfsw_pkg.sv
// Shared constants for the bit field stream writer: operation codes,
// register indexes, widths and reset defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfsw_pkg;

    // Operation codes carried on func
    localparam logic [2:0] FUNC_UNSIGNED = 3'd0;
    localparam logic [2:0] FUNC_SIGNED   = 3'd1;
    localparam logic [2:0] FUNC_VARINT   = 3'd2;
    localparam logic [2:0] FUNC_ZIGZAG   = 3'd3;
    localparam logic [2:0] FUNC_READ     = 3'd4;
    localparam logic [2:0] FUNC_RESTART  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_LIMIT_BITS = 2'd0;
    localparam logic [1:0] CFG_START_BIT  = 2'd1;

    // Field widths
    localparam int POS_W     = 14;
    localparam int START_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 32;
    localparam int VARINT_MAX_BYTES = 10;
    localparam int ENC_W     = 8 * VARINT_MAX_BYTES;

    // Reset values and defaults
    localparam logic [POS_W-1:0]   LIMIT_RESET = 14'd8192;
    localparam logic [START_W-1:0] START_RESET = 13'd0;
    localparam int BUFFER_WORDS_DEF = 256;

    // Varint byte layout and signed-field mask
    localparam logic [7:0]  VARINT_MORE    = 8'h80;
    localparam logic [6:0]  VARINT_PAYLOAD = 7'h7F;
    localparam logic [31:0] SIGN_PRESERVE  = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

### rtl/core/bit_field_stream_writer_unit.sv
// Bit field stream writer: top level with the word buffer memory and its
// read-modify-write sequencer. Depends on bfsw_pkg.
//
// Usage:
//   An item (func, value, field_width, word_index) is taken on a clock edge
//   with start high and busy low. Each item gives one result, shown for one
//   cycle with done high: overflowed, bit_pos and word_data.
//   Config: cfg_wr_en writes cfg_data to limit_bits (index 0) or start_bit
//   (index 1); other indexes are ignored. Write only while idle.
//   Steps from accept to the done cycle:
//     restart and unused codes: done in the next cycle, busy stays low.
//     read word: one buffer read, then the result.
//     field and varint writes: a plan step, then one read and one write
//     per buffer word touched (W = 0..4); a 32-bit field touches one or
//     two words, a full 10-byte varint three or four.
//   A new item can be accepted in the done cycle of the previous one.
//   Reset clears the position and overflow flag and loads limit 8192 and
//   start 0; buffer contents are undefined until written.
//   The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module bit_field_stream_writer_unit
    import bfsw_pkg::*;
#(
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_data,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           func,
    input  wire logic [63:0]          value,
    input  wire logic [5:0]           field_width,
    input  wire logic [7:0]           word_index,
    // result channel
    output logic                      done,
    output logic                      overflowed,
    output logic [POS_W-1:0]          bit_pos,
    output logic [WORD_W-1:0]         word_data
);

    localparam int AW     = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int WADR_W = 10;   // word index of position plus spill words
    localparam int LEN_W  = 7;    // up to 80 bits per item

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_RD,
        ST_WR,
        ST_RDW
    } state_t;

    state_t state_reg;

    // configuration
    logic [POS_W-1:0]   limit_reg;
    logic [START_W-1:0] start_reg;

    // architectural state
    logic [POS_W-1:0] pos_reg;
    logic             ovf_reg;

    // item and sequencer registers
    logic [ENC_W-1:0]  enc_reg;
    logic [LEN_W-1:0]  need_reg;
    logic              varint_reg;
    logic [ENC_W-1:0]  rem_data_reg;
    logic [LEN_W-1:0]  rem_len_reg;
    logic [WADR_W-1:0] addr_reg;
    logic [4:0]        offset_reg;
    logic              rd_in_range_reg;
    logic              done_reg;
    logic [WORD_W-1:0] word_data_reg;

    // buffer memory
    logic [WORD_W-1:0] mem [BUFFER_WORDS];
    logic [WORD_W-1:0] mem_rdata_reg;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);

    // ---------------------------------------------------------------
    // Item encoding at accept
    // ---------------------------------------------------------------
    logic [5:0]       n_clamp;
    logic [63:0]      zz_value;
    logic [63:0]      vsrc;
    logic [3:0]       vbytes;
    logic [ENC_W-1:0] varint_enc;
    logic [31:0]      sign_bit;
    logic [31:0]      signed_enc;
    logic [ENC_W-1:0] enc_next;
    logic [LEN_W-1:0] need_next;

    always_comb
    begin
        n_clamp  = (field_width > 6'd32) ? 6'd32 : field_width;
        zz_value = {value[62:0], 1'b0} ^ {64{value[63]}};
        vsrc     = (func == FUNC_ZIGZAG) ? zz_value : value;

        // byte count: highest nonzero 7-bit group
        vbytes = 4'd1;
        for (int i = 1; i < VARINT_MAX_BYTES; i++)
        begin
            if ((7'(vsrc >> (7 * i)) & VARINT_PAYLOAD) != 7'd0)
                vbytes = 4'(i + 1);
        end

        // groups with continuation bits
        varint_enc = '0;
        for (int i = 0; i < VARINT_MAX_BYTES; i++)
        begin
            varint_enc[8*i +: 8] = {1'b0, 7'(vsrc >> (7 * i)) & VARINT_PAYLOAD}
                                 | ((4'(i) < vbytes - 4'd1) ? VARINT_MORE : 8'h00);
        end

        // signed field: bit n-1 carries the sign of the 32-bit value
        sign_bit   = 32'(1) << (n_clamp - 6'd1);
        signed_enc = (value[31:0] & ~sign_bit) | (value[31] ? sign_bit : 32'd0);

        case (func)
            FUNC_UNSIGNED:
            begin
                enc_next  = ENC_W'(value[31:0]);
                need_next = LEN_W'(n_clamp);
            end
            FUNC_SIGNED:
            begin
                enc_next  = ENC_W'(signed_enc & (SIGN_PRESERVE | ~SIGN_PRESERVE));
                need_next = LEN_W'(n_clamp);
            end
            FUNC_VARINT, FUNC_ZIGZAG:
            begin
                enc_next  = varint_enc;
                need_next = LEN_W'({vbytes, 3'b000});
            end
            default:
            begin
                enc_next  = '0;
                need_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Fit check: whole write, or for varints the bytes that still fit
    // ---------------------------------------------------------------
    logic [POS_W:0]   end_pos;
    logic             fits_all;
    logic [POS_W-1:0] avail;
    logic [LEN_W-1:0] write_len_next;
    logic [POS_W-1:0] pos_next;

    always_comb
    begin
        end_pos  = (POS_W+1)'(pos_reg) + (POS_W+1)'(need_reg);
        fits_all = end_pos <= (POS_W+1)'(limit_reg);
        avail    = (limit_reg >= pos_reg) ? (limit_reg - pos_reg) : '0;
        if (fits_all)
            write_len_next = need_reg;
        else if (varint_reg)
            write_len_next = LEN_W'({avail[6:3], 3'b000});
        else
            write_len_next = '0;
        pos_next = fits_all ? end_pos[POS_W-1:0] : limit_reg;
    end

    // ---------------------------------------------------------------
    // One word of a write: chunk, mask and merge
    // ---------------------------------------------------------------
    logic [5:0]        room;
    logic [5:0]        chunk;
    logic [WORD_W-1:0] chunk_mask;
    logic [WORD_W-1:0] chunk_data;
    logic              wr_in_range;
    logic              rd_in_range;

    always_comb
    begin
        room  = 6'd32 - 6'(offset_reg);
        chunk = (LEN_W'(room) < rem_len_reg) ? room : rem_len_reg[5:0];
        if (chunk == 6'd32)
            chunk_mask = '1;
        else
            chunk_mask = ((32'(1) << chunk) - 32'd1) << offset_reg;
        chunk_data  = rem_data_reg[WORD_W-1:0] << offset_reg;
        wr_in_range = 32'(addr_reg) < 32'(BUFFER_WORDS);
        rd_in_range = 32'(word_index) < 32'(BUFFER_WORDS);
    end

    // buffer port control; one access per cycle, never overlapping
    always_comb
    begin
        mem_re    = (accept && (func == FUNC_READ)) || (state_reg == ST_RD);
        mem_raddr = (state_reg == ST_IDLE) ? AW'(32'(word_index)) : AW'(32'(addr_reg));
        mem_we    = (state_reg == ST_WR) && wr_in_range;
        mem_waddr = AW'(32'(addr_reg));
        mem_wdata = (mem_rdata_reg & ~chunk_mask) | (chunk_data & chunk_mask);
    end

    // buffer memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // Sequencer, state and registered results
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_RESET;
            start_reg       <= START_RESET;
            pos_reg         <= '0;
            ovf_reg         <= 1'b0;
            done_reg        <= 1'b0;
            word_data_reg   <= '0;
            enc_reg         <= '0;
            need_reg        <= '0;
            varint_reg      <= 1'b0;
            rem_data_reg    <= '0;
            rem_len_reg     <= '0;
            addr_reg        <= '0;
            offset_reg      <= '0;
            rd_in_range_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            // config writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_LIMIT_BITS: limit_reg <= cfg_data;
                    CFG_START_BIT:  start_reg <= cfg_data[START_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        enc_reg         <= enc_next;
                        need_reg        <= need_next;
                        varint_reg      <= (func == FUNC_VARINT) || (func == FUNC_ZIGZAG);
                        rd_in_range_reg <= rd_in_range;
                        word_data_reg   <= '0;
                        case (func)
                            FUNC_UNSIGNED, FUNC_SIGNED, FUNC_VARINT, FUNC_ZIGZAG:
                                state_reg <= ST_PLAN;
                            FUNC_READ:
                                state_reg <= ST_RDW;
                            FUNC_RESTART:
                            begin
                                pos_reg  <= POS_W'(start_reg);
                                ovf_reg  <= 1'b0;
                                done_reg <= 1'b1;
                            end
                            default:
                                done_reg <= 1'b1;
                        endcase
                    end
                end

                // position update and write length
                ST_PLAN:
                begin
                    pos_reg      <= pos_next;
                    ovf_reg      <= ovf_reg | !fits_all;
                    rem_data_reg <= enc_reg;
                    rem_len_reg  <= write_len_next;
                    addr_reg     <= WADR_W'(pos_reg[POS_W-1:5]);
                    offset_reg   <= pos_reg[4:0];
                    if (write_len_next == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RD;
                    end
                end

                ST_RD:
                    state_reg <= ST_WR;

                // merge and write back, then step to the next word
                ST_WR:
                begin
                    rem_data_reg <= rem_data_reg >> chunk;
                    rem_len_reg  <= rem_len_reg - LEN_W'(chunk);
                    addr_reg     <= addr_reg + WADR_W'(1);
                    offset_reg   <= '0;
                    if (rem_len_reg == LEN_W'(chunk))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RD;
                    end
                end

                ST_RDW:
                begin
                    word_data_reg <= rd_in_range_reg ? mem_rdata_reg : '0;
                    done_reg      <= 1'b1;
                    state_reg     <= ST_IDLE;
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign overflowed = ovf_reg;
    assign bit_pos    = pos_reg;
    assign word_data  = word_data_reg;

endmodule

`default_nettype wire

### rtl/core/bfsw_checker.sv
// Port-level checks for the bit field stream writer, bound to the top level.
// Depends on bfsw_pkg and bit_field_stream_writer_unit.
`timescale 1ns / 1ps
`default_nettype none

module bfsw_checker
    import bfsw_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [2:0]       func,
    input wire logic             done,
    input wire logic             overflowed
);

    logic accepted;
    assign accepted = start && !busy;

    // an accepted item either keeps the block busy or finishes at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> (busy || done))
        else $error("accepted item neither busy nor done");

    // results appear only once the sequencer is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // restart answers next cycle with a clear flag
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted && (func == FUNC_RESTART)) |=> (done && !overflowed))
        else $error("restart result wrong");

    // the overflow flag clears only by restart
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(overflowed) |-> $past(accepted && (func == FUNC_RESTART)))
        else $error("overflow flag cleared without restart");

    // busy starts only with an accepted item
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");

endmodule

bind bit_field_stream_writer_unit bfsw_checker u_bfsw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .done       (done),
    .overflowed (overflowed)
);

`default_nettype wire

### bench/bit_field_stream_writer_unit_tb.sv
// Self-checking bench for bit_field_stream_writer_unit: sends commands and
// register writes, predicts each result with a behavioral model and compares.
// Depends on bfsw_pkg and the bit_field_stream_writer_unit RTL.
`timescale 1ns / 1ps

module bit_field_stream_writer_unit_tb;
    import bfsw_pkg::*;

    localparam int NUM_WORDS = BUFFER_WORDS_DEF;
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] START_MAX = 14'd8191;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int RANDOM_PHASES = 10;

    typedef struct packed {
        logic             ovf;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] word;
    } wr_status_t;

    // DUT ports
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic [2:0]           func;
    logic [63:0]          value;
    logic [5:0]           field_width;
    logic [7:0]           word_index;
    logic                 done;
    logic                 overflowed;
    logic [POS_W-1:0]     bit_pos;
    logic [WORD_W-1:0]    word_data;

    // Writer model state
    logic [WORD_W-1:0] buf_mdl [NUM_WORDS];
    int unsigned       cur_pos;
    int unsigned       lim_bits;
    int unsigned       restart_pos;
    logic              ovf_flag;

    wr_status_t status_q[$];
    int         err_count;
    int         stall_cycles;
    bit         gaps_on;

    bit_field_stream_writer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .value       (value),
        .field_width (field_width),
        .word_index  (word_index),
        .done        (done),
        .overflowed  (overflowed),
        .bit_pos     (bit_pos),
        .word_data   (word_data)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------
    function automatic void store_masked(int unsigned w, logic [31:0] data,
                                         logic [31:0] mask);
        // words past the buffer end are dropped
        if (w < NUM_WORDS)
            buf_mdl[w] = (buf_mdl[w] & ~mask) | (data & mask);
    endfunction

    function automatic void pack_bits(logic [31:0] data, int unsigned n);
        int unsigned sh;
        int unsigned w;
        logic [63:0] m;
        logic [63:0] d;
        // no fit: jump to the limit and flag it, nothing written
        if (cur_pos + n > lim_bits)
        begin
            cur_pos  = lim_bits;
            ovf_flag = 1'b1;
            return;
        end
        if (n == 0)
            return;
        sh = cur_pos % 32;
        w  = cur_pos / 32;
        m  = (n >= 32) ? 64'hFFFF_FFFF : ((64'd1 << n) - 64'd1);
        m  = m << sh;
        d  = ({32'b0, data} << sh) & m;
        store_masked(w, d[31:0], m[31:0]);
        if (m[63:32] != 0)
            store_masked(w + 1, d[63:32], m[63:32]);
        cur_pos += n;
    endfunction

    // LEB128: 7 payload bits per byte, each byte fit-checked on its own
    function automatic void emit_varint(logic [63:0] v);
        while (v > {57'b0, VARINT_PAYLOAD})
        begin
            pack_bits({24'b0, VARINT_MORE | {1'b0, v[6:0]}}, 8);
            v = v >> 7;
        end
        pack_bits({25'b0, v[6:0]}, 8);
    endfunction

    function automatic wr_status_t predict_status(logic [2:0] f, logic [63:0] v,
                                                  logic [5:0] fw, logic [7:0] idx);
        int unsigned n;
        logic [31:0] keep;
        logic [31:0] sval;
        logic [31:0] word;
        n    = (fw > 32) ? 32 : fw;
        word = '0;
        case (f)
            FUNC_UNSIGNED: pack_bits(v[31:0], n);
            FUNC_SIGNED:
            begin
                // low n-1 bits kept, sign bit moved to the top of the field
                sval = '0;
                if (n != 0)
                begin
                    keep = SIGN_PRESERVE >> (32 - n);
                    sval = v[31:0] & keep;
                    if (v[31])
                        sval |= ~keep;
                end
                pack_bits(sval, n);
            end
            FUNC_VARINT: emit_varint(v);
            FUNC_ZIGZAG: emit_varint((v << 1) ^ {64{v[63]}});
            FUNC_READ: word = buf_mdl[idx];
            FUNC_RESTART:
            begin
                cur_pos  = restart_pos;
                ovf_flag = 1'b0;
            end
            default: ;
        endcase
        return '{ovf: ovf_flag, pos: cur_pos[POS_W-1:0], word: word};
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // spread varint lengths from one to ten bytes
    function automatic logic [63:0] varint_value();
        return rand64() >> $urandom_range(0, 63);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    // drop start for a random while, with junk on the command fields
    task automatic idle_gap();
        int n;
        n = gaps_on ? pick_gap() : 0;
        if (n > 0)
        begin
            start       <= 1'b0;
            func        <= $urandom;
            value       <= rand64();
            field_width <= $urandom;
            word_index  <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    // one item; returns at the edge where it was taken
    task automatic send_item(logic [2:0] f, logic [63:0] v, logic [5:0] fw,
                             logic [7:0] idx);
        idle_gap();
        start       <= 1'b1;
        func        <= f;
        value       <= v;
        field_width <= fw;
        word_index  <= idx;
        do
            @(posedge clk);
        while (busy);
        status_q.push_back(predict_status(f, v, fw, idx));
    endtask

    task automatic send_restart();
        send_item(FUNC_RESTART, rand64(), $urandom, $urandom);
    endtask

    // wait out every pending result, then let the sequencer settle
    task automatic go_idle();
        start <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // limit, start, then a write to an unused index that must be ignored
    task automatic set_config(logic [POS_W-1:0] lim, logic [POS_W-1:0] st);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LIMIT_BITS;
        cfg_data  <= lim;
        @(posedge clk);
        lim_bits  = lim;
        cfg_index <= CFG_START_BIT;
        cfg_data  <= st;
        @(posedge clk);
        restart_pos = st[START_W-1:0];
        cfg_index <= CFG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_index <= $urandom;
        cfg_data  <= $urandom;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // write every buffer word in full, exact fit, then one bit too many
    task automatic test_fill_buffer();
        send_restart();
        for (int i = 0; i < NUM_WORDS; i++)
            send_item(FUNC_UNSIGNED, rand64(), 6'd32, $urandom);
        send_item(FUNC_UNSIGNED, rand64(), 6'd1, $urandom);
        send_item(FUNC_READ, rand64(), $urandom, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd255);
    endtask

    task automatic test_field_edges();
        send_restart();
        send_item(FUNC_UNSIGNED, 64'd1, 6'd1, 8'd0);
        send_item(FUNC_UNSIGNED, '1, 6'd32, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd0, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd63, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd33, 8'd0);
        send_item(FUNC_SIGNED, '1, 6'd1, 8'd0);
        send_item(FUNC_SIGNED, 64'd0, 6'd1, 8'd0);
        send_item(FUNC_SIGNED, 64'h7FFF_FFFF, 6'd32, 8'd0);
        send_item(FUNC_SIGNED, 64'h8000_0000, 6'd32, 8'd0);
        send_item(FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFFD, 6'd5, 8'd0);
        send_item(FUNC_SIGNED, rand64(), 6'd0, 8'd0);
        send_item(FUNC_SIGNED, rand64(), 6'd40, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd1);
        send_item(FUNC_READ, rand64(), $urandom, 8'd2);
        send_item(FUNC_SPARE_A, rand64(), $urandom, $urandom);
        send_item(FUNC_SPARE_B, rand64(), $urandom, $urandom);
    endtask

    task automatic test_varint_coding();
        send_restart();
        send_item(FUNC_VARINT, 64'd0, $urandom, 8'd0);
        send_item(FUNC_VARINT, 64'd127, $urandom, 8'd0);
        send_item(FUNC_VARINT, 64'd128, $urandom, 8'd0);
        send_item(FUNC_VARINT, 64'd300, $urandom, 8'd0);
        send_item(FUNC_VARINT, '1, $urandom, 8'd0);
        send_item(FUNC_ZIGZAG, 64'd0, $urandom, 8'd0);
        send_item(FUNC_ZIGZAG, '1, $urandom, 8'd0);
        send_item(FUNC_ZIGZAG, 64'd1, $urandom, 8'd0);
        send_item(FUNC_ZIGZAG, 64'h8000_0000_0000_0000, $urandom, 8'd0);
        send_item(FUNC_ZIGZAG, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, 8'd0);
        for (int i = 0; i < 8; i++)
            send_item(FUNC_READ, rand64(), $urandom, i);
    endtask

    task automatic test_overflow();
        // field that does not fit, then a zero-width write right at the limit
        go_idle();
        set_config(14'd40, 14'd0);
        send_restart();
        send_item(FUNC_UNSIGNED, rand64(), 6'd32, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd16, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd0, 8'd0);
        send_item(FUNC_VARINT, 64'd5, $urandom, 8'd0);
        // varints that overflow part way through
        go_idle();
        set_config(14'd20, 14'd0);
        send_restart();
        send_item(FUNC_VARINT, 64'd300, $urandom, 8'd0);
        send_item(FUNC_VARINT, 64'd300, $urandom, 8'd0);
        send_restart();
        send_item(FUNC_ZIGZAG, 64'd1 << 20, $urandom, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd0);
        // restart point beyond the limit: even a zero-width write overflows
        go_idle();
        set_config(14'd10, 14'd50);
        send_restart();
        send_item(FUNC_UNSIGNED, rand64(), 6'd0, 8'd0);
        send_item(FUNC_SPARE_A, rand64(), $urandom, $urandom);
        // zero limit
        go_idle();
        set_config(14'd0, 14'd0);
        send_restart();
        send_item(FUNC_UNSIGNED, rand64(), 6'd0, 8'd0);
        send_item(FUNC_SIGNED, rand64(), 6'd1, 8'd0);
    endtask

    task automatic test_past_buffer_end();
        // limit past the buffer: bits beyond the last word are dropped
        go_idle();
        set_config(POS_MAX, 14'd8180);
        send_restart();
        send_item(FUNC_UNSIGNED, rand64(), 6'd32, 8'd0);
        send_item(FUNC_VARINT, '1, $urandom, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd255);
        // start value with bit 13 set is cut to 13 bits
        go_idle();
        set_config(POS_MAX, POS_MAX);
        send_restart();
        send_item(FUNC_SIGNED, rand64(), 6'd32, 8'd0);
        send_item(FUNC_READ, rand64(), $urandom, 8'd255);
        // run the position up to the top of the 14-bit range
        for (int i = 0; i < 105; i++)
            send_item(FUNC_ZIGZAG, 64'h8000_0000_0000_0000, $urandom, 8'd0);
        send_item(FUNC_UNSIGNED, rand64(), 6'd0, 8'd0);
        send_restart();
    endtask

    task automatic test_random_traffic();
        logic [POS_W-1:0] lim;
        logic [POS_W-1:0] st;
        int               rst_pct;
        int               r;
        logic [2:0]       f;
        logic [5:0]       fw;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            go_idle();
            case (p)
                0:
                begin
                    lim = LIMIT_RESET;
                    st  = START_RESET;
                end
                1:
                begin
                    lim = POS_MAX;
                    st  = START_MAX;
                end
                2:
                begin
                    lim = 14'd0;
                    st  = 14'd0;
                end
                default:
                begin
                    lim = ($urandom_range(0, 9) < 7) ? $urandom_range(64, 8192)
                                                      : $urandom_range(0, 16383);
                    st  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(0, lim / 2);
                end
            endcase
            set_config(lim, st);
            rst_pct = $urandom_range(1, 12);
            gaps_on = ($urandom_range(0, 3) != 0);
            send_restart();
            for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++)
            begin
                r  = $urandom_range(0, 99);
                fw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(1, 32);
                if (r < rst_pct)
                    send_restart();
                else if (r < rst_pct + 12)
                    send_item(FUNC_READ, rand64(), $urandom, $urandom);
                else if (r < rst_pct + 14)
                begin
                    f = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
                    send_item(f, rand64(), $urandom, $urandom);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: send_item(FUNC_UNSIGNED, rand64(), fw, $urandom);
                        1: send_item(FUNC_SIGNED, rand64(), fw, $urandom);
                        2: send_item(FUNC_VARINT, varint_value(), fw, $urandom);
                        default: send_item(FUNC_ZIGZAG, varint_value(), fw, $urandom);
                    endcase
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        wr_status_t want;
        if (rst_n && done)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: result with no item pending: ovf=%0b pos=%0d word=%h",
                         $time, overflowed, bit_pos, word_data);
                err_count++;
            end
            else
            begin
                want = status_q.pop_front();
                if (overflowed !== want.ovf)
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.ovf, overflowed);
                    err_count++;
                end
                if (bit_pos !== want.pos)
                begin
                    $display("%0t: bit_pos expected %0d actual %0d",
                             $time, want.pos, bit_pos);
                    err_count++;
                end
                if (word_data !== want.word)
                begin
                    $display("%0t: word_data expected %h actual %h",
                             $time, want.word, word_data);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither an item taken nor a result shown
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_LIMIT_BITS;
        cfg_data    <= '0;
        start       <= 1'b0;
        func        <= FUNC_UNSIGNED;
        value       <= '0;
        field_width <= '0;
        word_index  <= '0;
        err_count    = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        cur_pos      = 0;
        ovf_flag     = 1'b0;
        lim_bits     = LIMIT_RESET;
        restart_pos  = START_RESET;
        foreach (buf_mdl[i])
            buf_mdl[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_buffer();
        test_field_edges();
        test_varint_coding();
        test_overflow();
        test_past_buffer_end();
        test_random_traffic();

        go_idle();
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/bfsw_pkg.sv
rtl/core/bit_field_stream_writer_unit.sv
rtl/core/bfsw_checker.sv
bench/bit_field_stream_writer_unit_tb.sv
